/* rtl/dspm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dspm_pkg;

    // Widths fixed by the register map and the result format.
    localparam int END_W      = 16;
    localparam int MARK_W     = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_END_A_X     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_END_A_Y     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_END_B_X     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_END_B_Y     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SEVERE      = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_LOW_MARK    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_HIGH_MARK   = 3'd6;

    // Register values after reset.
    localparam logic [MARK_W-1:0] LOW_MARK_RESET  = 16'd1;
    localparam logic [MARK_W-1:0] HIGH_MARK_RESET = 16'd2;

endpackage

`default_nettype wire

/* rtl/defect_segment_pixel_mask_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel      Direction  Contents
// s_axis       in         tdata: pixel_x, pixel_y (COORD_BITS each, zero fill to bytes)
// m_axis       out        tdata: mark (16 bits); tuser: hit (1 bit)
// cfg          in         cfg_we, cfg_addr (register index), cfg_wdata (16 bits)
//
// One item per cycle is accepted unless a stalled result holds the pipe back.
// The depth is set by the chain subtract, products, sums, clamp select, the
// cross product square (about 34 by 34 bits) and the final compare.
// Reset clears all valid bits and loads the register defaults.
// A stalled result holds every stage that is full behind it; empty stages still fill.
module defect_segment_pixel_mask_top
    import dspm_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 4
)(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // pixel_x [COORD_BITS-1:0], pixel_y [2*COORD_BITS-1:COORD_BITS]
    input  wire logic [((2*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // mark [15:0]
    output logic [MARK_W-1:0]                          m_axis_tdata,
    // hit [0]
    output logic                                       m_axis_tuser,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    input  wire logic                                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]                 cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]                 cfg_wdata
);

    // Scaled pixel width, signed difference width, product and sum widths.
    localparam int PW   = COORD_BITS + FRAC_BITS;
    localparam int DW   = ((PW > END_W) ? PW : END_W) + 1;
    localparam int PRW  = 2 * DW;
    localparam int SW   = 2 * DW + 1;
    localparam int AW   = 2 * DW;
    localparam int NW   = SW + 2 * FRAC_BITS + 2;
    localparam int CMPW = 2 * AW + 2 * FRAC_BITS + 2;
    localparam int NST  = 6;

    // Configuration registers.
    logic [END_W-1:0]  end_a_x_reg, end_a_y_reg, end_b_x_reg, end_b_y_reg;
    logic              severe_reg;
    logic [MARK_W-1:0] low_mark_reg, high_mark_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_a_x_reg   <= '0;
            end_a_y_reg   <= '0;
            end_b_x_reg   <= '0;
            end_b_y_reg   <= '0;
            severe_reg    <= 1'b0;
            low_mark_reg  <= LOW_MARK_RESET;
            high_mark_reg <= HIGH_MARK_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_END_A_X:   end_a_x_reg   <= cfg_wdata[END_W-1:0];
                REG_END_A_Y:   end_a_y_reg   <= cfg_wdata[END_W-1:0];
                REG_END_B_X:   end_b_x_reg   <= cfg_wdata[END_W-1:0];
                REG_END_B_Y:   end_b_y_reg   <= cfg_wdata[END_W-1:0];
                REG_SEVERE:    severe_reg    <= cfg_wdata[0];
                REG_LOW_MARK:  low_mark_reg  <= cfg_wdata[MARK_W-1:0];
                REG_HIGH_MARK: high_mark_reg <= cfg_wdata[MARK_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage valid bits and load enables; a stage loads when it is empty or
    // the stage after it moves on.
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] en;

    always_comb
    begin
        en[NST-1] = !vld_reg[NST-1] || m_axis_tready;
        for (int i = NST - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= s_axis_tvalid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Stage 1: scale the pixel onto the endpoint grid and take differences.
    logic [PW-1:0]        px, py;
    logic signed [DW-1:0] ax_s, ay_s, bx_s, by_s, px_s, py_s;
    logic signed [DW-1:0] ex_reg, ey_reg, pax_reg, pay_reg, pbx_reg, pby_reg;

    assign px   = PW'(s_axis_tdata[COORD_BITS-1:0]) << FRAC_BITS;
    assign py   = PW'(s_axis_tdata[2*COORD_BITS-1:COORD_BITS]) << FRAC_BITS;
    assign px_s = $signed(DW'(px));
    assign py_s = $signed(DW'(py));
    assign ax_s = $signed(DW'(end_a_x_reg));
    assign ay_s = $signed(DW'(end_a_y_reg));
    assign bx_s = $signed(DW'(end_b_x_reg));
    assign by_s = $signed(DW'(end_b_y_reg));

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            ex_reg  <= bx_s - ax_s;
            ey_reg  <= by_s - ay_s;
            pax_reg <= px_s - ax_s;
            pay_reg <= py_s - ay_s;
            pbx_reg <= px_s - bx_s;
            pby_reg <= py_s - by_s;
        end
    end

    // Stage 2: all products, one multiplier deep.
    logic signed [PRW-1:0] exex_reg, eyey_reg, expax_reg, eypay_reg;
    logic signed [PRW-1:0] expay_reg, eypax_reg;
    logic signed [PRW-1:0] paxsq_reg, paysq_reg, pbxsq_reg, pbysq_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            exex_reg  <= ex_reg * ex_reg;
            eyey_reg  <= ey_reg * ey_reg;
            expax_reg <= ex_reg * pax_reg;
            eypay_reg <= ey_reg * pay_reg;
            expay_reg <= ex_reg * pay_reg;
            eypax_reg <= ey_reg * pax_reg;
            paxsq_reg <= pax_reg * pax_reg;
            paysq_reg <= pay_reg * pay_reg;
            pbxsq_reg <= pbx_reg * pbx_reg;
            pbysq_reg <= pby_reg * pby_reg;
        end
    end

    // Stage 3: length squared, dot and cross products, end distances squared.
    logic signed [SW-1:0] len2_3_reg, dot_reg, cross_reg, da2_reg, db2_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            len2_3_reg <= SW'(exex_reg) + SW'(eyey_reg);
            dot_reg    <= SW'(expax_reg) + SW'(eypay_reg);
            cross_reg  <= SW'(expay_reg) - SW'(eypax_reg);
            da2_reg    <= SW'(paxsq_reg) + SW'(paysq_reg);
            db2_reg    <= SW'(pbxsq_reg) + SW'(pbysq_reg);
        end
    end

    // Stage 4: clamp the projection to an end or keep the interior case,
    // test the end distance, and take the magnitude of the cross product.
    logic              to_a, to_b;
    logic              near_a, near_b;
    logic [NW-1:0]     near_lim;
    logic [SW-1:0]     cross_neg;
    logic              mid_4_reg, near_end_4_reg;
    logic [AW-1:0]     cabs_reg;
    logic [SW-2:0]     len2_4_reg;

    assign to_a      = (len2_3_reg == '0) || (dot_reg <= 0);
    assign to_b      = !to_a && (dot_reg >= len2_3_reg);
    assign near_lim  = NW'(1) << (2 * FRAC_BITS);
    assign near_a    = {NW'(da2_reg[SW-2:0]), 1'b0} <= {1'b0, near_lim};
    assign near_b    = {NW'(db2_reg[SW-2:0]), 1'b0} <= {1'b0, near_lim};
    assign cross_neg = -cross_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            mid_4_reg      <= !to_a && !to_b;
            near_end_4_reg <= to_a ? near_a : near_b;
            cabs_reg       <= cross_reg[SW-1] ? cross_neg[AW-1:0] : cross_reg[AW-1:0];
            len2_4_reg     <= len2_3_reg[SW-2:0];
        end
    end

    // Stage 5: square of the cross product.
    logic [2*AW-1:0] c2_reg;
    logic            mid_5_reg, near_end_5_reg;
    logic [SW-2:0]   len2_5_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            c2_reg         <= cabs_reg * cabs_reg;
            mid_5_reg      <= mid_4_reg;
            near_end_5_reg <= near_end_4_reg;
            len2_5_reg     <= len2_4_reg;
        end
    end

    // Stage 6: interior test 2*c^2 <= len2 * 2^(2*FRAC_BITS), then the mark.
    logic [CMPW-1:0]   cmp_lhs, cmp_rhs;
    logic              hit_next;
    logic [MARK_W-1:0] mark_next;
    logic [MARK_W-1:0] mark_reg;
    logic              hit_reg;

    assign cmp_lhs   = CMPW'({c2_reg, 1'b0});
    assign cmp_rhs   = CMPW'(len2_5_reg) << (2 * FRAC_BITS);
    assign hit_next  = mid_5_reg ? (cmp_lhs <= cmp_rhs) : near_end_5_reg;
    assign mark_next = hit_next ? (severe_reg ? high_mark_reg : low_mark_reg) : '0;

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            mark_reg <= mark_next;
            hit_reg  <= hit_next;
        end
    end

    assign m_axis_tdata = mark_reg;
    assign m_axis_tuser = hit_reg;

    // A miss always carries a zero mark.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("miss result with nonzero mark");

    // An accepted item occupies the first stage on the next edge.
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> vld_reg[0])
        else $error("accepted item lost at pipeline entry");

    // The interior case never arises for a degenerate segment.
    a_mid_len: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[3] && mid_4_reg |-> len2_4_reg != '0)
        else $error("interior projection on a zero-length segment");

endmodule

`default_nettype wire

/* tb/dspm_mask_checker.sv */
`timescale 1ns / 1ps

module dspm_mask_checker
    import dspm_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 4
)(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // pixel_x, pixel_y
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata,
    input  logic                                  s_axis_tvalid,
    input  logic                                  s_axis_tready,
    // mark
    input  logic [MARK_W-1:0]                     m_axis_tdata,
    // hit
    input  logic                                  m_axis_tuser,
    input  logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    input  logic                                  cfg_we,
    input  logic [CFG_ADDR_W-1:0]                 cfg_addr,
    input  logic [CFG_DATA_W-1:0]                 cfg_wdata,
    output int                                    mismatches,
    output int                                    pending,
    output int                                    results_seen,
    output int                                    hits_seen
);

    // Beyond this many, mismatches are still counted but no longer printed.
    localparam int REPORT_CAP = 100;

    typedef struct packed {
        logic [MARK_W-1:0] mark;
        logic              hit;
    } pixel_result_t;

    // Local copy of the register file, tracked from the write port.
    logic [END_W-1:0]  seg_ax, seg_ay, seg_bx, seg_by;
    logic              is_severe;
    logic [MARK_W-1:0] mark_low, mark_high;

    // Predicted results, oldest first.
    pixel_result_t expected_marks[$];

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_CAP)
        begin
            $display("%0t ns: mismatch: %s", $time, what);
        end
    endtask

    // Exact point-to-segment test on the 2^-FRAC_BITS pixel grid.
    function automatic pixel_result_t predict_mark(input logic [COORD_BITS-1:0] pix_x,
                                                   input logic [COORD_BITS-1:0] pix_y);
        longint        px, py, ex, ey, pax, pay, pbx, pby;
        longint        len2, dot, cross_mag, d2, half_lim;
        logic [127:0]  cross_wide, cross_sq2, len_scaled;
        logic          near;
        pixel_result_t res;

        px = longint'(pix_x) <<< FRAC_BITS;
        py = longint'(pix_y) <<< FRAC_BITS;
        ex = longint'(seg_bx) - longint'(seg_ax);
        ey = longint'(seg_by) - longint'(seg_ay);
        pax = px - longint'(seg_ax);
        pay = py - longint'(seg_ay);
        len2 = ex * ex + ey * ey;
        dot = ex * pax + ey * pay;
        // A hit needs 2*d2 <= 2^(2*FRAC_BITS), i.e. a squared distance of at most one half pixel squared.
        half_lim = longint'(1) <<< (2 * FRAC_BITS);

        if (len2 == 0 || dot <= 0)
        begin
            // Point segment, or nearest point clamped to end A.
            d2 = pax * pax + pay * pay;
            near = (2 * d2 <= half_lim);
        end
        else if (dot >= len2)
        begin
            // Nearest point clamped to end B.
            pbx = px - longint'(seg_bx);
            pby = py - longint'(seg_by);
            d2 = pbx * pbx + pby * pby;
            near = (2 * d2 <= half_lim);
        end
        else
        begin
            // Interior: compare 2*cross^2 with len2 scaled, in 128 bits.
            cross_mag = ex * pay - ey * pax;
            if (cross_mag < 0)
            begin
                cross_mag = -cross_mag;
            end
            cross_wide = {64'd0, cross_mag};
            cross_sq2 = (cross_wide * cross_wide) << 1;
            len_scaled = {64'd0, len2} << (2 * FRAC_BITS);
            near = (cross_sq2 <= len_scaled);
        end

        res.hit = near;
        res.mark = near ? (is_severe ? mark_high : mark_low) : '0;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_result_t want;
        if (!rst_n)
        begin
            seg_ax = '0;
            seg_ay = '0;
            seg_bx = '0;
            seg_by = '0;
            is_severe = 1'b0;
            mark_low = LOW_MARK_RESET;
            mark_high = HIGH_MARK_RESET;
            expected_marks.delete();
            pending = 0;
        end
        else
        begin
            // Track register writes; unknown indexes change nothing.
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_END_A_X:   seg_ax = cfg_wdata[END_W-1:0];
                    REG_END_A_Y:   seg_ay = cfg_wdata[END_W-1:0];
                    REG_END_B_X:   seg_bx = cfg_wdata[END_W-1:0];
                    REG_END_B_Y:   seg_by = cfg_wdata[END_W-1:0];
                    REG_SEVERE:    is_severe = cfg_wdata[0];
                    REG_LOW_MARK:  mark_low = cfg_wdata[MARK_W-1:0];
                    REG_HIGH_MARK: mark_high = cfg_wdata[MARK_W-1:0];
                    default:       ;
                endcase
            end

            // Every accepted pixel yields exactly one result.
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_marks.push_back(predict_mark(
                    s_axis_tdata[COORD_BITS-1:0],
                    s_axis_tdata[2*COORD_BITS-1:COORD_BITS]));
            end

            // Compare each accepted result with the oldest prediction.
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (m_axis_tuser === 1'b1)
                begin
                    hits_seen++;
                end
                if (expected_marks.size() == 0)
                begin
                    report_mismatch($sformatf("result mark=%0d hit=%0b with no pixel pending",
                                              m_axis_tdata, m_axis_tuser));
                end
                else
                begin
                    want = expected_marks.pop_front();
                    if (m_axis_tdata !== want.mark)
                    begin
                        report_mismatch($sformatf("mark %0d, expected %0d",
                                                  m_axis_tdata, want.mark));
                    end
                    if (m_axis_tuser !== want.hit)
                    begin
                        report_mismatch($sformatf("hit %0b, expected %0b",
                                                  m_axis_tuser, want.hit));
                    end
                end
            end

            pending = expected_marks.size();
        end
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
    import dspm_pkg::*;

    localparam int COORD_BITS    = 12;
    localparam int FRAC_BITS     = 4;
    localparam int TDATA_W       = ((2*COORD_BITS+7)/8)*8;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int LONG_HOLD     = 80;
    localparam int RANDOM_PHASES = 14;
    localparam int PHASE_ITEMS   = 125;
    localparam int PIXEL_MAX     = (1 << COORD_BITS) - 1;
    localparam int END_MAX       = (1 << END_W) - 1;

    // First index past the register map; the block must ignore writes to it.
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic [TDATA_W-1:0]    s_axis_tdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [MARK_W-1:0]     m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int mismatches;
    int pending;
    int results_seen;
    int hits_seen;
    int cycle_count    = 0;
    int pixels_sent    = 0;
    int segments_tried = 0;
    bit hold_req       = 1'b0;

    // Segment ends as last written; used only to aim pixels near the line.
    int seg_ax = 0;
    int seg_ay = 0;
    int seg_bx = 0;
    int seg_by = 0;

    defect_segment_pixel_mask_top #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    dspm_mask_checker #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .mismatches    (mismatches),
        .pending       (pending),
        .results_seen  (results_seen),
        .hits_seen     (hits_seen)
    );

    // Clock with a 2 ns period.
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles, %0d results outstanding",
                     cycle_count, pending);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Idle lengths: mostly short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 95)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // End coordinates and marks, with the range extremes favored.
    function automatic int pick_end();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return END_MAX;
            default: return $urandom_range(0, END_MAX);
        endcase
    endfunction

    function automatic int clamp_end(input int v);
        if (v < 0)
        begin
            return 0;
        end
        if (v > END_MAX)
        begin
            return END_MAX;
        end
        return v;
    endfunction

    // Pixel index near the point a + (b - a) * t / 1024, nudged by jitter.
    function automatic int near_coord(input int a_end, input int b_end,
                                      input int t, input int jitter);
        int pt;
        pt = a_end + ((b_end - a_end) * t) / 1024;
        pt = ((pt + (1 << (FRAC_BITS - 1))) >>> FRAC_BITS) + jitter;
        if (pt < 0)
        begin
            return 0;
        end
        if (pt > PIXEL_MAX)
        begin
            return PIXEL_MAX;
        end
        return pt;
    endfunction

    // Result side: random stalls in modes, plus a long hold on request.
    initial
    begin
        int stall;
        int ready_mode;
        int mode_left;
        m_axis_tready <= 1'b0;
        ready_mode = 0;
        mode_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                ready_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_req = 1'b0;
                m_axis_tready <= 1'b1;
            end
            else if ((ready_mode == 1 && $urandom_range(0, 7) == 0) ||
                     (ready_mode == 2 && $urandom_range(0, 1) == 0))
            begin
                stall = pick_gap();
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // One register write per cycle; the caller lowers the write enable.
    task automatic set_reg(input logic [CFG_ADDR_W-1:0] idx, input int value);
        cfg_addr <= idx;
        cfg_wdata <= value[CFG_DATA_W-1:0];
        cfg_we <= 1'b1;
        @(negedge clk);
    endtask

    // Writes the whole register map; only called while the block is idle.
    task automatic load_segment(input int ax, input int ay, input int bx, input int by,
                                input int severe_word, input int low, input int high,
                                input bit poke_spare);
        seg_ax = ax;
        seg_ay = ay;
        seg_bx = bx;
        seg_by = by;
        set_reg(REG_END_A_X, ax);
        set_reg(REG_END_A_Y, ay);
        set_reg(REG_END_B_X, bx);
        set_reg(REG_END_B_Y, by);
        set_reg(REG_SEVERE, severe_word);
        set_reg(REG_LOW_MARK, low);
        set_reg(REG_HIGH_MARK, high);
        if (poke_spare)
        begin
            set_reg(REG_SPARE, $urandom);
        end
        cfg_we <= 1'b0;
        segments_tried++;
    endtask

    // Offers one pixel, after an optional gap, and waits for its acceptance.
    task automatic send_pixel(input int x, input int y, input int gap_pct);
        int gap;
        gap = ($urandom_range(0, 99) < gap_pct) ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata <= TDATA_W'({y[COORD_BITS-1:0], x[COORD_BITS-1:0]});
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
        pixels_sent++;
    endtask

    // Stops offering and waits until every result is out and the pipe is empty.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Stimulus and verdict.
    initial
    begin
        int x, y, t, ax, ay, bx, by, gap_pct;
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        cfg_we <= 1'b0;
        cfg_addr <= '0;
        cfg_wdata <= '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Reset registers: a point segment at the origin, moderate mark 1.
        send_pixel(0, 0, 30);
        send_pixel(1, 0, 30);
        send_pixel(PIXEL_MAX, PIXEL_MAX, 30);
        send_pixel(PIXEL_MAX, 0, 30);
        send_pixel(0, PIXEL_MAX, 30);
        drain();

        // Point at (0.5, 0.5): four neighbors sit exactly on the half limit.
        // Severe is set with all upper bits high; a spare index is written too.
        load_segment(8, 8, 8, 8, 16'hFFFF, 0, END_MAX, 1'b1);
        send_pixel(0, 0, 30);
        send_pixel(1, 1, 30);
        send_pixel(1, 0, 30);
        send_pixel(0, 1, 30);
        send_pixel(2, 1, 30);
        drain();

        // Diagonal from the origin: interior pixels on and just off the limit,
        // and pixels past end B. Severe bit 0 with upper bits set.
        load_segment(0, 0, 160, 160, 16'hFFFE, END_MAX, 0, 1'b0);
        send_pixel(1, 0, 30);
        send_pixel(5, 4, 30);
        send_pixel(3, 5, 30);
        send_pixel(5, 5, 30);
        send_pixel(10, 11, 30);
        send_pixel(11, 11, 30);
        drain();

        // Ends at the extremes of their range, across the whole frame.
        load_segment(END_MAX, 0, 0, END_MAX, 1, 1234, 4321, 1'b0);
        send_pixel(PIXEL_MAX, 0, 30);
        send_pixel(2047, 2048, 30);
        send_pixel(PIXEL_MAX, PIXEL_MAX, 30);
        drain();

        // Half-pixel ends: before end A, past end B, and an interior boundary.
        load_segment(168, 168, 328, 328, 0, 16'h5A5A, 16'hA5A5, 1'b0);
        send_pixel(10, 10, 30);
        send_pixel(21, 21, 30);
        send_pixel(9, 9, 30);
        send_pixel(15, 16, 30);
        drain();

        // Random segments, mostly probed close to the line.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            ax = pick_end();
            ay = pick_end();
            case (phase % 5)
                0:
                begin
                    bx = pick_end();
                    by = pick_end();
                end
                1:
                begin
                    bx = clamp_end(ax + int'($urandom_range(0, 128)) - 64);
                    by = clamp_end(ay + int'($urandom_range(0, 128)) - 64);
                end
                2:
                begin
                    bx = ax;
                    by = ay;
                end
                3:
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        bx = pick_end();
                        by = ay;
                    end
                    else
                    begin
                        bx = ax;
                        by = pick_end();
                    end
                end
                default:
                begin
                    ax = $urandom_range(0, 1) * END_MAX;
                    ay = $urandom_range(0, 1) * END_MAX;
                    bx = $urandom_range(0, 1) * END_MAX;
                    by = $urandom_range(0, 1) * END_MAX;
                end
            endcase
            load_segment(ax, ay, bx, by, $urandom, pick_end(), pick_end(), phase % 3 == 0);

            case ($urandom_range(0, 3))
                0:       gap_pct = 0;
                1:       gap_pct = 5;
                2:       gap_pct = 25;
                default: gap_pct = 60;
            endcase
            // Back-to-back pixels against a long result hold fill the pipe.
            if (phase % 7 == 3)
            begin
                gap_pct = 0;
                hold_req = 1'b1;
            end

            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (phase == 6 && i == PHASE_ITEMS / 2)
                begin
                    drain();
                end
                if ($urandom_range(0, 3) == 0)
                begin
                    x = $urandom_range(0, PIXEL_MAX);
                    y = $urandom_range(0, PIXEL_MAX);
                end
                else
                begin
                    t = int'($urandom_range(0, 1279)) - 128;
                    x = near_coord(seg_ax, seg_bx, t, int'($urandom_range(0, 2)) - 1);
                    y = near_coord(seg_ay, seg_by, t, int'($urandom_range(0, 2)) - 1);
                end
                send_pixel(x, y, gap_pct);
            end
            drain();
        end

        $display("Sent %0d pixels over %0d segment setups: points, clamped ends, interior",
                 pixels_sent, segments_tried);
        $display("boundary cases and stalls; %0d results compared, %0d hits, %0d mismatches.",
                 results_seen, hits_seen, mismatches);
        if (mismatches == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/dspm_pkg.sv
rtl/defect_segment_pixel_mask_top.sv
tb/dspm_mask_checker.sv
tb/tb.sv
